[rtl/pfa_pkg.sv]
`timescale 1ns / 1ps

package pfa_pkg;

    localparam int MODE_W    = 2;
    localparam int SIZE_W    = 16;
    localparam int STATUS_W  = 3;
    localparam int OUT_IDX_W = 4;
    localparam int POLICY_W  = 2;

    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_WAIT      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd4;

    localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

    // microcode addresses
    typedef enum logic [2:0] {
        STEP_FETCH,
        STEP_CLEAR,
        STEP_APPEND,
        STEP_SCAN,
        STEP_FINISH
    } step_t;

    typedef enum logic [1:0] {
        SEQ_DISPATCH,   // wait for an item, jump by its mode
        SEQ_GOTO,       // jump to target once the step executes
        SEQ_LOOP        // jump to target while the scan goes on, else fall through
    } seq_cond_t;

    typedef enum logic [2:0] {
        ACT_FETCH,
        ACT_CLEAR,
        ACT_APPEND,
        ACT_SCAN,
        ACT_FINISH
    } act_t;

    typedef struct packed {
        seq_cond_t cond;
        step_t     target;
        act_t      act;
        logic      emit;     // step loads the result register
    } ctl_word_t;

    // sequencer -> datapath
    typedef struct packed {
        act_t act;
        logic fire;          // step executes this cycle
    } seq_ctl_t;

    // datapath -> sequencer
    typedef struct packed {
        logic              accept;
        logic [MODE_W-1:0] mode;
        logic              out_busy;
        logic              more;
    } seq_stat_t;

    function automatic ctl_word_t ucode(step_t s);
        ctl_word_t w;
        unique case (s)
            STEP_FETCH:  w = '{SEQ_DISPATCH, STEP_FETCH, ACT_FETCH,  1'b0};
            STEP_CLEAR:  w = '{SEQ_GOTO,     STEP_FETCH, ACT_CLEAR,  1'b1};
            STEP_APPEND: w = '{SEQ_GOTO,     STEP_FETCH, ACT_APPEND, 1'b1};
            STEP_SCAN:   w = '{SEQ_LOOP,     STEP_SCAN,  ACT_SCAN,   1'b0};
            STEP_FINISH: w = '{SEQ_GOTO,     STEP_FETCH, ACT_FINISH, 1'b1};
            default:     w = '{SEQ_GOTO,     STEP_FETCH, ACT_FETCH,  1'b0};
        endcase
        return w;
    endfunction

    function automatic step_t dispatch_step(logic [MODE_W-1:0] mode);
        step_t s;
        unique case (mode)
            MODE_CLEAR:  s = STEP_CLEAR;
            MODE_APPEND: s = STEP_APPEND;
            MODE_ALLOC:  s = STEP_SCAN;
            default:     s = STEP_FETCH;
        endcase
        return s;
    endfunction

endpackage

[rtl/pfa_in_if.sv]
`timescale 1ns / 1ps

interface pfa_in_if
    import pfa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [SIZE_W-1:0] size_kb;

    modport source (output valid, output mode, output size_kb, input ready);
    modport sink   (input valid, input mode, input size_kb, output ready);
endinterface

[rtl/pfa_out_if.sv]
`timescale 1ns / 1ps

interface pfa_out_if
    import pfa_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [OUT_IDX_W-1:0] partition_index;
    logic [SIZE_W-1:0]    free_before;
    logic [SIZE_W-1:0]    free_after;

    modport source (output valid, output status, output partition_index,
                    output free_before, output free_after, input ready);
    modport sink   (input valid, input status, input partition_index,
                    input free_before, input free_after, output ready);
endinterface

[rtl/pfa_ram.sv]
`timescale 1ns / 1ps

module pfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

[rtl/pfa_seq.sv]
`timescale 1ns / 1ps

module pfa_seq
    import pfa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  seq_stat_t stat,
    output seq_ctl_t  ctl
);
    step_t     step_reg;
    step_t     step_next;
    ctl_word_t word;
    logic      fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_FETCH;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_comb
    begin
        word      = ucode(step_reg);
        // a result step holds while the result register is still occupied
        fire      = !(word.emit && stat.out_busy);
        step_next = step_reg;
        unique case (word.cond)
            SEQ_DISPATCH:
            begin
                if (stat.accept)
                begin
                    step_next = dispatch_step(stat.mode);
                end
            end
            SEQ_GOTO:
            begin
                if (fire)
                begin
                    step_next = word.target;
                end
            end
            SEQ_LOOP:
            begin
                step_next = stat.more ? word.target : step_t'(step_reg + 3'd1);
            end
            default:
            begin
                step_next = STEP_FETCH;
            end
        endcase
        ctl.act  = word.act;
        ctl.fire = fire;
    end

    a_alloc_scans: assert property (@(posedge clk) disable iff (!rst_n)
        stat.accept && stat.mode == MODE_ALLOC |=> step_reg == STEP_SCAN)
        else $error("allocate did not enter the scan loop");

    a_none_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        stat.accept && stat.mode == MODE_NONE |=> step_reg == STEP_FETCH)
        else $error("unused mode left the fetch step");

    a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg == STEP_SCAN && !stat.more |=> step_reg == STEP_FINISH)
        else $error("scan loop did not exit to finish");
endmodule

[rtl/partition_fit_allocator.sv]
`timescale 1ns / 1ps

// Partition fit allocator. Keeps free sizes (KB) of up to MAX_PARTITIONS
// partitions in a RAM with separate write and read ports and handles one
// item at a time: clear the table, append a partition, or allocate a request
// under the fit_policy register (first, best or worst fit; ties go to the
// lower index). One result item per accepted item, except mode 3 which is
// dropped silently. The scan walks the RAM read port one entry per cycle:
// clear and append are an accept step and a result step; an allocation is
// the accept step, one scan step per stored entry (at least one on an empty
// table) and a finish step; first fit stops at the first entry that fits.
// A result step waits while the output register is still occupied.
// A new item is taken while the previous result still waits in the output
// register. There is no clearing pass after reset; only entries below the
// count are ever compared.
module partition_fit_allocator
    import pfa_pkg::*;
#(
    parameter int MAX_PARTITIONS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    pfa_in_if.sink            req,
    pfa_out_if.source         rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PARTITIONS);
    localparam logic REG_FIT_POLICY = 1'b0;    // word index, paddr[2]

    // ---------------- config register ----------------
    logic [POLICY_W-1:0] policy_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FIT_POLICY) ? {{(32-POLICY_W){1'b0}}, policy_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_FIRST;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_FIT_POLICY)
        begin
            policy_reg <= pwdata[POLICY_W-1:0];
        end
    end

    // ---------------- sequencer ----------------
    seq_stat_t stat;
    seq_ctl_t  ctl;
    logic      accept;

    pfa_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    assign req.ready = (ctl.act == ACT_FETCH);
    assign accept    = req.valid && req.ready;

    // ---------------- datapath state ----------------
    logic [SIZE_W-1:0]    size_reg,      size_next;
    logic [CNT_W-1:0]     cnt_reg,       cnt_next;
    logic [CNT_W-1:0]     scan_reg,      scan_next;
    logic                 found_reg,     found_next;
    logic [IDX_W-1:0]     best_idx_reg,  best_idx_next;
    logic [SIZE_W-1:0]    best_free_reg, best_free_next;
    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  status_reg,    status_next;
    logic [OUT_IDX_W-1:0] oidx_reg,      oidx_next;
    logic [SIZE_W-1:0]    before_reg,    before_next;
    logic [SIZE_W-1:0]    after_reg,     after_next;

    // RAM port
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [SIZE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [SIZE_W-1:0] ram_rdata;

    pfa_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (MAX_PARTITIONS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // scan helpers
    logic                    first_fit;
    logic                    hit;
    logic                    take;
    logic                    more;
    logic [CNT_W-1:0]        scan_inc;
    logic [IDX_W+OUT_IDX_W-1:0] best_idx_ext;
    logic [CNT_W+OUT_IDX_W-1:0] cnt_ext;

    assign first_fit    = (policy_reg != POLICY_BEST) && (policy_reg != POLICY_WORST);
    assign scan_inc     = scan_reg + 1'b1;
    // entry under compare is live only below the count (empty table: never)
    assign hit          = (scan_reg < cnt_reg) && (ram_rdata >= size_reg);
    assign best_idx_ext = {{OUT_IDX_W{1'b0}}, best_idx_reg};
    assign cnt_ext      = {{OUT_IDX_W{1'b0}}, cnt_reg};

    always_comb
    begin
        priority if (!hit)
        begin
            take = 1'b0;
        end
        else if (!found_reg)
        begin
            take = 1'b1;
        end
        else if (policy_reg == POLICY_BEST)
        begin
            take = ram_rdata < best_free_reg;
        end
        else if (policy_reg == POLICY_WORST)
        begin
            take = ram_rdata > best_free_reg;
        end
        else
        begin
            take = 1'b0;
        end
    end

    assign more = (scan_inc < cnt_reg) && !(first_fit && (found_reg || hit));

    assign stat.accept   = accept;
    assign stat.mode     = req.mode;
    assign stat.out_busy = out_valid_reg && !rsp.ready;
    assign stat.more     = more;

    always_comb
    begin
        size_next      = size_reg;
        cnt_next       = cnt_reg;
        scan_next      = scan_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_free_next = best_free_reg;
        status_next    = status_reg;
        oidx_next      = oidx_reg;
        before_next    = before_reg;
        after_next     = after_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        ram_we         = 1'b0;
        ram_waddr      = best_idx_reg;
        ram_wdata      = size_reg;
        ram_re         = 1'b0;
        ram_raddr      = scan_inc[IDX_W-1:0];

        unique case (ctl.act)
            ACT_FETCH:
            begin
                // latch the item and prefetch entry 0 for a possible scan
                if (accept)
                begin
                    size_next  = req.size_kb;
                    scan_next  = '0;
                    found_next = 1'b0;
                    ram_re     = 1'b1;
                    ram_raddr  = '0;
                end
            end
            ACT_CLEAR:
            begin
                if (ctl.fire)
                begin
                    cnt_next       = '0;
                    out_valid_next = 1'b1;
                    status_next    = ST_CLEARED;
                    oidx_next      = '0;
                    before_next    = '0;
                    after_next     = '0;
                end
            end
            ACT_APPEND:
            begin
                if (ctl.fire)
                begin
                    out_valid_next = 1'b1;
                    if (cnt_reg >= CNT_MAX)
                    begin
                        status_next = ST_FULL;
                        oidx_next   = '0;
                        before_next = '0;
                        after_next  = '0;
                    end
                    else
                    begin
                        ram_we      = 1'b1;
                        ram_waddr   = cnt_reg[IDX_W-1:0];
                        ram_wdata   = size_reg;
                        cnt_next    = cnt_reg + 1'b1;
                        status_next = ST_ADDED;
                        oidx_next   = cnt_ext[OUT_IDX_W-1:0];
                        before_next = size_reg;
                        after_next  = size_reg;
                    end
                end
            end
            ACT_SCAN:
            begin
                // compare entry scan_reg, fetch the next one if the scan goes on
                if (take)
                begin
                    found_next     = 1'b1;
                    best_idx_next  = scan_reg[IDX_W-1:0];
                    best_free_next = ram_rdata;
                end
                scan_next = scan_inc;
                ram_re    = more;
            end
            ACT_FINISH:
            begin
                if (ctl.fire)
                begin
                    out_valid_next = 1'b1;
                    if (found_reg)
                    begin
                        ram_we      = 1'b1;
                        ram_waddr   = best_idx_reg;
                        ram_wdata   = best_free_reg - size_reg;
                        status_next = ST_ALLOCATED;
                        oidx_next   = best_idx_ext[OUT_IDX_W-1:0];
                        before_next = best_free_reg;
                        after_next  = best_free_reg - size_reg;
                    end
                    else
                    begin
                        status_next = ST_WAIT;
                        oidx_next   = '0;
                        before_next = '0;
                        after_next  = '0;
                    end
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !rsp.ready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg      <= size_next;
        scan_reg      <= scan_next;
        best_idx_reg  <= best_idx_next;
        best_free_reg <= best_free_next;
        status_reg    <= status_next;
        oidx_reg      <= oidx_next;
        before_reg    <= before_next;
        after_reg     <= after_next;
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = status_reg;
    assign rsp.partition_index = oidx_reg;
    assign rsp.free_before     = before_reg;
    assign rsp.free_after      = after_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_MAX)
        else $error("partition count beyond table size");

    a_pick_fits: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.act == ACT_FINISH && found_reg |-> best_free_reg >= size_reg)
        else $error("chosen partition smaller than request");

    a_alloc_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == ST_ALLOCATED |-> after_reg <= before_reg)
        else $error("allocation grew a partition");
endmodule
